@@ hdl/hoard_pkg.sv @@
// Package: payload types and function codes for the hot object detector.
`timescale 1ns / 1ps
package hoard_pkg;
   localparam logic [2:0] FUNC_ACCESS = 3'd0;
   localparam logic [2:0] FUNC_ABORT  = 3'd1;
   localparam logic [2:0] FUNC_DETECT = 3'd2;
   localparam logic [2:0] FUNC_QUERY  = 3'd3;
   localparam logic [2:0] FUNC_LIST   = 3'd4;

   localparam logic [1:0] CSR_ENABLE    = 2'd0;
   localparam logic [1:0] CSR_MIN_ACC   = 2'd1;
   localparam logic [1:0] CSR_THRESHOLD = 2'd2;

   localparam logic [31:0] CNT_MAX = 32'hFFFF_FFFF;

   typedef struct packed {
      logic [2:0]  func;
      logic [63:0] object_key;
      logic [63:0] time_now;
   } req_type;

   typedef struct packed {
      logic [63:0] entry_key;
      logic        hot_flag;
      logic [31:0] accesses_seen;
      logic [31:0] aborts_seen;
      logic [63:0] hot_since;
      logic        entry_valid;
      logic        table_full_drop;
      logic        last_of_run;
   } rsp_type;

   // One table entry as it travels along the row of cells.
   typedef struct packed {
      logic        used;
      logic [63:0] key;
      logic [31:0] acc;
      logic [31:0] abt;
      logic        hot;
      logic [63:0] hot_time;
   } entry_type;

   // Command for one rotation step; its shift bit goes to every cell.
   typedef struct packed {
      logic        shift;     // rotate the row by one place
      logic        judge;     // re-judge the entry leaving the head
      logic        bump_acc;  // count an access on the head entry
      logic        bump_abt;  // count an abort on the head entry
      logic        alloc;     // load a fresh entry into the head
      logic [63:0] key;
      logic [63:0] now;
   } cmd_type;
endpackage

@@ hdl/hoard_cell.sv @@
// Cell: one table entry, loads from its upstream neighbour on a rotation step.
`timescale 1ns / 1ps
module hoard_cell (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  shift,
   input  hoard_pkg::entry_type  entry_in,
   output hoard_pkg::entry_type  entry_out
);
   import hoard_pkg::*;

   entry_type entry_ff;
   logic      used_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff <= 1'b0;
      end else if (shift) begin
         used_ff <= entry_in.used;
      end
   end

   always_ff @(posedge clock) begin
      if (shift) begin
         entry_ff <= entry_in;
      end
   end

   always_comb begin
      entry_out      = entry_ff;
      entry_out.used = used_ff;
   end
endmodule

@@ hdl/hoard_head.sv @@
// Head stage: updates the entry that wraps from the row tail back to its start.
`timescale 1ns / 1ps
module hoard_head #(
   parameter int RATE_FRAC_BITS = 16
) (
   input  hoard_pkg::cmd_type    cmd,
   input  logic [31:0]           min_acc,
   input  logic [16:0]           threshold,
   input  hoard_pkg::entry_type  tail_entry,
   output hoard_pkg::entry_type  head_entry
);
   import hoard_pkg::*;

   localparam int LW = 32 + RATE_FRAC_BITS;
   localparam int PW = 49;
   localparam int CW = (LW > PW) ? LW : PW;

   logic [CW-1:0] lhs, rhs;
   logic [48:0]   prod;
   logic          hot_now;
   entry_type     upd;

   // Product of threshold and access count; one 17x32 multiply.
   assign prod = 49'(threshold) * 49'(tail_entry.acc);
   assign lhs  = CW'({tail_entry.abt, {RATE_FRAC_BITS{1'b0}}});
   assign rhs  = CW'(prod);
   assign hot_now = (tail_entry.acc >= min_acc) && (lhs > rhs);

   always_comb begin
      upd = tail_entry;
      if (cmd.alloc) begin
         upd.used     = 1'b1;
         upd.key      = cmd.key;
         upd.acc      = 32'd0;
         upd.abt      = 32'd0;
         upd.hot      = 1'b0;
         upd.hot_time = 64'd0;
      end
      if (cmd.bump_acc && upd.acc != CNT_MAX) upd.acc = upd.acc + 32'd1;
      if (cmd.bump_abt && upd.abt != CNT_MAX) upd.abt = upd.abt + 32'd1;
      if (cmd.judge && tail_entry.used) begin
         upd.hot = hot_now;
         if (hot_now && !tail_entry.hot) upd.hot_time = cmd.now;
      end
   end

   assign head_entry = upd;
endmodule

@@ hdl/hot_object_abort_rate_detector_core.sv @@
// Top level: hot object abort-rate detector built as a rotating row of cells.
`timescale 1ns / 1ps
// Every item walks the table twice: a scan lap of TABLE_DEPTH rotation steps
// finds the key and a free slot, an action lap of TABLE_DEPTH steps applies it.
// The closing result is registered in ST_DONE once the action lap ends; one
// item is in flight, and the next is taken only after that result has been
// accepted, later under result stalls. List results leave at most one per cycle.
// Reset: synchronous, active high; clears slot valid marks and control,
// enable=1, min_accesses=0, rate_threshold=32768. No clearing pass.
module hot_object_abort_rate_detector_core #(
   parameter int TABLE_DEPTH    = 32,
   parameter int RATE_FRAC_BITS = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  hoard_pkg::req_type   req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output hoard_pkg::rsp_type   rsp_data,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [1:0]           csr_index,
   input  logic [31:0]          csr_data
);
   import hoard_pkg::*;

   localparam int CW = $clog2(TABLE_DEPTH + 1);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_SCAN = 2'd1;  // first lap: find the key
   localparam logic [1:0] ST_WALK = 2'd2;  // second lap: act on the table
   localparam logic [1:0] ST_DONE = 2'd3;  // hand over the closing item

   // Configuration registers.
   logic        enable_ff;
   logic [31:0] min_acc_ff;
   logic [16:0] thresh_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff  <= 1'b1;
         min_acc_ff <= 32'd0;
         thresh_ff  <= 17'd32768;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_ENABLE:    enable_ff  <= csr_data[0];
            CSR_MIN_ACC:   min_acc_ff <= csr_data;
            CSR_THRESHOLD: thresh_ff  <= csr_data[16:0];
            default: ;
         endcase
      end
   end

   // Row of cells; the head stage closes the ring.
   entry_type row [TABLE_DEPTH];
   entry_type head_entry;
   cmd_type   cmd;

   for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
      hoard_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .shift     (cmd.shift),
         .entry_in  ((g == 0) ? head_entry : row[(g == 0) ? 0 : g - 1]),
         .entry_out (row[g])
      );
   end

   hoard_head #(.RATE_FRAC_BITS(RATE_FRAC_BITS)) u_head (
      .cmd        (cmd),
      .min_acc    (min_acc_ff),
      .threshold  (thresh_ff),
      .tail_entry (row[TABLE_DEPTH-1]),
      .head_entry (head_entry)
   );

   entry_type tail;
   assign tail = row[TABLE_DEPTH-1];

   // Sequencer state.
   logic [1:0]    state_ff, state_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   req_type       req_ff;
   logic          found_ff, found_in;   // key present in the table
   logic          free_ff, free_in;     // a free slot exists
   logic          done_ff, done_in;     // event already applied on this lap
   logic          any_ff, any_in;       // list emitted at least one item
   rsp_type       rsp_ff, rsp_in;
   logic          rsp_valid_ff, rsp_valid_in;
   rsp_type       pend_ff, pend_in;     // held query or list item, last flag decided later
   logic          pend_v_ff, pend_v_in;

   logic is_event, last_step, hit, stall;

   assign is_event  = (req_ff.func == FUNC_ACCESS) || (req_ff.func == FUNC_ABORT);
   assign last_step = (cnt_ff == CW'(TABLE_DEPTH - 1));
   assign hit       = tail.used && (tail.key == req_ff.object_key);
   assign stall     = rsp_valid_ff && !rsp_ready;
   assign req_ready = (state_ff == ST_IDLE) && !rsp_valid_ff;

   function automatic rsp_type entry_rsp(entry_type e);
      rsp_type r;
      r.entry_key       = e.key;
      r.hot_flag        = e.hot;
      r.accesses_seen   = e.acc;
      r.aborts_seen     = e.abt;
      r.hot_since       = e.hot_time;
      r.entry_valid     = 1'b1;
      r.table_full_drop = 1'b0;
      r.last_of_run     = 1'b0;
      return r;
   endfunction

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      found_in     = found_ff;
      free_in      = free_ff;
      done_in      = done_ff;
      any_in       = any_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      pend_in      = pend_ff;
      pend_v_in    = pend_v_ff;
      cmd          = '0;
      cmd.key      = req_ff.object_key;
      cmd.now      = req_ff.time_now;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid && req_ready && req_data.func <= FUNC_LIST) begin
               state_in  = ST_SCAN;
               cnt_in    = '0;
               found_in  = 1'b0;
               free_in   = 1'b0;
               done_in   = 1'b0;
               any_in    = 1'b0;
               pend_v_in = 1'b0;
            end
         end
         ST_SCAN: begin
            // Rotate once, gathering hit and free information; query answers here.
            cmd.shift = 1'b1;
            if (hit) begin
               found_in = 1'b1;
               if (req_ff.func == FUNC_QUERY) pend_in = entry_rsp(tail);
            end
            if (!tail.used) free_in = 1'b1;
            cnt_in = cnt_ff + CW'(1);
            if (last_step) begin
               cnt_in   = '0;
               state_in = ST_WALK;
            end
         end
         ST_WALK: begin
            // Second lap: apply the event, sweep, or stream hot entries.
            if (!(pend_v_ff && stall)) begin
               cmd.shift = 1'b1;
               if (enable_ff && is_event && !done_ff) begin
                  if (found_ff ? hit : (free_ff && !tail.used)) begin
                     cmd.alloc    = !found_ff;
                     cmd.bump_acc = (req_ff.func == FUNC_ACCESS);
                     cmd.bump_abt = (req_ff.func == FUNC_ABORT);
                     done_in      = 1'b1;
                  end
               end
               if (enable_ff && req_ff.func == FUNC_DETECT) cmd.judge = 1'b1;
               if (req_ff.func == FUNC_LIST && tail.used && tail.hot) begin
                  if (pend_v_ff) begin
                     rsp_in       = pend_ff;
                     rsp_valid_in = 1'b1;
                  end
                  pend_in   = entry_rsp(tail);
                  pend_v_in = 1'b1;
                  any_in    = 1'b1;
               end
               cnt_in = cnt_ff + CW'(1);
               if (last_step) state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!stall) begin
               rsp_valid_in = 1'b1;
               rsp_in       = '0;
               rsp_in.last_of_run = 1'b1;
               if (is_event) begin
                  if (enable_ff && !found_ff && !free_ff) begin
                     rsp_in.entry_key       = req_ff.object_key;
                     rsp_in.table_full_drop = 1'b1;
                  end
               end else if (req_ff.func == FUNC_QUERY) begin
                  if (found_ff) rsp_in = pend_ff;
                  else rsp_in.entry_key = req_ff.object_key;
                  rsp_in.last_of_run = 1'b1;
               end else if (req_ff.func == FUNC_LIST && any_ff) begin
                  rsp_in = pend_ff;
                  rsp_in.last_of_run = 1'b1;
               end
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         found_ff     <= 1'b0;
         free_ff      <= 1'b0;
         done_ff      <= 1'b0;
         any_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
         pend_v_ff    <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         found_ff     <= found_in;
         free_ff      <= free_in;
         done_ff      <= done_in;
         any_ff       <= any_in;
         rsp_valid_ff <= rsp_valid_in;
         pend_v_ff    <= pend_v_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff  <= rsp_in;
      pend_ff <= pend_in;
      if (req_valid && req_ready) req_ff <= req_data;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // Hold the result while the consumer stalls.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result changed under stall");
   // Accept no item while a walk is under way.
   assert property (@(posedge clock) disable iff (reset)
      state_ff != ST_IDLE |-> !req_ready)
      else $error("item accepted mid-walk");
   // An event is applied at most once per walk.
   assert property (@(posedge clock) disable iff (reset)
      done_ff && state_ff == ST_WALK |-> !(cmd.alloc || cmd.bump_acc || cmd.bump_abt))
      else $error("event applied twice");
endmodule

@@ tb/hot_object_abort_rate_detector_core_checker.sv @@
// Checker: watches the request, response and register channels, predicts and compares.
`timescale 1ns / 1ps
module hot_object_abort_rate_detector_core_checker #(
   parameter int TABLE_DEPTH    = 32,
   parameter int RATE_FRAC_BITS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_ready,
   input  hoard_pkg::req_type req_data,
   input  logic               rsp_valid,
   input  logic               rsp_ready,
   input  hoard_pkg::rsp_type rsp_data,
   input  logic               csr_valid,
   input  logic               csr_ready,
   input  logic [1:0]         csr_index,
   input  logic [31:0]        csr_data,
   output int                 fail_count,
   output int                 pending_count
);
   import hoard_pkg::*;

   logic        tbl_used [TABLE_DEPTH];
   logic [63:0] tbl_key  [TABLE_DEPTH];
   logic [31:0] tbl_acc  [TABLE_DEPTH];
   logic [31:0] tbl_abt  [TABLE_DEPTH];
   logic        tbl_hot  [TABLE_DEPTH];
   logic [63:0] tbl_since[TABLE_DEPTH];
   logic        cfg_enable;
   logic [31:0] cfg_min_acc;
   logic [16:0] cfg_threshold;
   rsp_type     expected_rsps[$];

   assign pending_count = expected_rsps.size();

   function automatic void enqueue_rsp(rsp_type r);
      expected_rsps = {expected_rsps, r};
   endfunction

   function automatic int lookup_slot(logic [63:0] key);
      for (int i = 0; i < TABLE_DEPTH; i++)
         if (tbl_used[i] && tbl_key[i] == key) return i;
      return -1;
   endfunction

   function automatic rsp_type entry_report(int i);
      rsp_type r;
      r = '0;
      r.entry_key     = tbl_key[i];
      r.hot_flag      = tbl_hot[i];
      r.accesses_seen = tbl_acc[i];
      r.aborts_seen   = tbl_abt[i];
      r.hot_since     = tbl_since[i];
      r.entry_valid   = 1'b1;
      return r;
   endfunction

   task automatic predict_item(req_type q);
      rsp_type r;
      rsp_type held;
      int i;
      logic [63:0] lhs, rhs;
      logic hot;
      int n;
      r = '0;
      r.last_of_run = 1'b1;
      held = '0;
      n = 0;
      case (q.func)
         FUNC_ACCESS, FUNC_ABORT: begin
            if (cfg_enable) begin
               i = lookup_slot(q.object_key);
               if (i < 0)
                  for (int j = 0; j < TABLE_DEPTH; j++)
                     if (!tbl_used[j]) begin
                        i = j;
                        tbl_used[j] = 1'b1; tbl_key[j] = q.object_key;
                        tbl_acc[j] = '0; tbl_abt[j] = '0;
                        tbl_hot[j] = 1'b0; tbl_since[j] = '0;
                        break;
                     end
               if (i < 0) begin
                  r.entry_key = q.object_key;
                  r.table_full_drop = 1'b1;
               end else if (q.func == FUNC_ACCESS) begin
                  if (tbl_acc[i] != CNT_MAX) tbl_acc[i]++;
               end else begin
                  if (tbl_abt[i] != CNT_MAX) tbl_abt[i]++;
               end
            end
            enqueue_rsp(r);
         end
         FUNC_DETECT: begin
            if (cfg_enable)
               for (int j = 0; j < TABLE_DEPTH; j++) begin
                  if (!tbl_used[j]) continue;
                  lhs = 64'(tbl_abt[j]) << RATE_FRAC_BITS;
                  rhs = 64'(cfg_threshold) * 64'(tbl_acc[j]);
                  hot = (tbl_acc[j] >= cfg_min_acc) && (lhs > rhs);
                  if (hot && !tbl_hot[j]) tbl_since[j] = q.time_now;
                  tbl_hot[j] = hot;
               end
            enqueue_rsp(r);
         end
         FUNC_QUERY: begin
            i = lookup_slot(q.object_key);
            if (i >= 0) begin
               r = entry_report(i);
               r.last_of_run = 1'b1;
            end else r.entry_key = q.object_key;
            enqueue_rsp(r);
         end
         FUNC_LIST: begin
            // Hold each hot entry back one step so the final one can be flagged.
            for (int j = 0; j < TABLE_DEPTH; j++)
               if (tbl_used[j] && tbl_hot[j]) begin
                  if (n > 0) enqueue_rsp(held);
                  held = entry_report(j);
                  n++;
               end
            if (n == 0) enqueue_rsp(r);
            else begin
               held.last_of_run = 1'b1;
               enqueue_rsp(held);
            end
         end
         default: ;
      endcase
   endtask

   task automatic compare_rsp(rsp_type got);
      rsp_type e;
      if (expected_rsps.size() == 0) begin
         $error("unexpected item: entry_key %h", got.entry_key);
         fail_count++;
         return;
      end
      e = expected_rsps.pop_front();
      if (got != e) fail_count++;
      if (got.entry_key != e.entry_key)
         $error("entry_key expected %h actual %h", e.entry_key, got.entry_key);
      if (got.hot_flag != e.hot_flag)
         $error("hot_flag expected %0d actual %0d", e.hot_flag, got.hot_flag);
      if (got.accesses_seen != e.accesses_seen)
         $error("accesses_seen expected %0d actual %0d", e.accesses_seen, got.accesses_seen);
      if (got.aborts_seen != e.aborts_seen)
         $error("aborts_seen expected %0d actual %0d", e.aborts_seen, got.aborts_seen);
      if (got.hot_since != e.hot_since)
         $error("hot_since expected %h actual %h", e.hot_since, got.hot_since);
      if (got.entry_valid != e.entry_valid)
         $error("entry_valid expected %0d actual %0d", e.entry_valid, got.entry_valid);
      if (got.table_full_drop != e.table_full_drop)
         $error("table_full_drop expected %0d actual %0d",
                e.table_full_drop, got.table_full_drop);
      if (got.last_of_run != e.last_of_run)
         $error("last_of_run expected %0d actual %0d", e.last_of_run, got.last_of_run);
   endtask

   initial fail_count = 0;

   always @(posedge clock) begin
      if (reset) begin
         for (int j = 0; j < TABLE_DEPTH; j++) tbl_used[j] = 1'b0;
         cfg_enable = 1'b1;
         cfg_min_acc = '0;
         cfg_threshold = 17'd32768;
         expected_rsps.delete();
      end else begin
         // Responses first: the block answers no item in its acceptance cycle.
         if (rsp_valid && rsp_ready) compare_rsp(rsp_data);
         if (csr_valid && csr_ready)
            case (csr_index)
               CSR_ENABLE:    cfg_enable = csr_data[0];
               CSR_MIN_ACC:   cfg_min_acc = csr_data;
               CSR_THRESHOLD: cfg_threshold = csr_data[16:0];
               default: ;
            endcase
         if (req_valid && req_ready) predict_item(req_data);
      end
   end
endmodule

@@ tb/hot_object_abort_rate_detector_core_test.sv @@
// Testbench top: drives stimulus into the detector and gives the verdict.
`timescale 1ns / 1ps
module hot_object_abort_rate_detector_core_test;
   import hoard_pkg::*;

   logic    clock;
   logic    reset;
   logic    req_valid, req_ready;
   req_type req_data;
   logic    rsp_valid, rsp_ready;
   rsp_type rsp_data;
   logic    csr_valid, csr_ready;
   logic [1:0]  csr_index;
   logic [31:0] csr_data;
   int      fail_count, pending_count;
   bit      hold_off;
   logic [63:0] key_pool[8];

   hot_object_abort_rate_detector_core dut (.*);
   hot_object_abort_rate_detector_core_checker check (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Hard limit, well past the slowest legal run, including up to 32 stalled list
   // results per item.
   initial begin
      #50ms;
      $display("hot_object_abort_rate_detector_core test failed");
      $finish;
   end

   // Short gaps mostly, an occasional long one.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 45) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   // Response side: random stalls, plus one long hold-off while items pile up.
   initial begin
      bit hold_used;
      int gap;
      hold_used = 1'b0;
      rsp_ready = 1'b0;
      @(posedge clock iff !reset);
      forever begin
         if (hold_off && !hold_used) begin
            hold_used = 1'b1;
            rsp_ready <= 1'b0;
            repeat (300) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         gap = ($urandom_range(0, 2) == 0) ? pick_gap() : 0;
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   end

   task automatic send_item(logic [2:0] f, logic [63:0] key, logic [63:0] now);
      @(posedge clock);
      repeat (pick_gap()) @(posedge clock);
      req_valid <= 1'b1;
      req_data  <= '{func: f, object_key: key, time_now: now};
      @(posedge clock iff req_ready);
      req_valid <= 1'b0;
   endtask

   task automatic write_reg(logic [1:0] idx, logic [31:0] val);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      @(posedge clock iff csr_ready);
      csr_valid <= 1'b0;
   endtask

   // Drain, then let the last sweep finish before touching registers.
   task automatic settle();
      @(posedge clock iff pending_count == 0);
      repeat (40) @(posedge clock);
   endtask

   function automatic logic [63:0] rand64();
      return {$urandom(), $urandom()};
   endfunction

   task automatic random_phase(int count, int fill_bias);
      int r;
      logic [2:0] f;
      for (int n = 0; n < count; n++) begin
         r = $urandom_range(0, 99);
         if (r < 40)      f = FUNC_ACCESS;
         else if (r < 65) f = FUNC_ABORT;
         else if (r < 78) f = FUNC_DETECT;
         else if (r < 88) f = FUNC_QUERY;
         else if (r < 96) f = FUNC_LIST;
         else             f = 3'($urandom_range(5, 7));
         // Mostly revisit a small key set so counters build up; some fresh keys.
         send_item(f, ($urandom_range(0, 99) < fill_bias) ? rand64()
                       : key_pool[$urandom_range(0, 7)], rand64());
      end
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0; req_data = '0;
      csr_valid = 1'b0; csr_index = CSR_ENABLE; csr_data = '0;
      hold_off = 1'b0;
      for (int k = 0; k < 8; k++) key_pool[k] = rand64();
      key_pool[0] = '0;
      key_pool[1] = '1;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: extremes, every function, disabled, full table, zero accesses.
      send_item(FUNC_LIST, '0, '0);                 // empty list
      send_item(FUNC_QUERY, '1, '0);                // query miss
      send_item(FUNC_ABORT, key_pool[0], '0);       // aborts with no accesses
      send_item(FUNC_DETECT, '0, '1);
      send_item(FUNC_ACCESS, key_pool[1], '0);
      send_item(FUNC_ACCESS, key_pool[1], '0);
      send_item(FUNC_ABORT, key_pool[1], '0);
      send_item(FUNC_DETECT, '0, 64'h1234);
      send_item(FUNC_QUERY, key_pool[0], '0);
      send_item(FUNC_LIST, '0, '0);
      send_item(3'd5, '1, '1);
      send_item(3'd7, '0, '0);
      settle();
      write_reg(CSR_ENABLE, 32'd0);
      send_item(FUNC_ACCESS, key_pool[2], '0);
      send_item(FUNC_DETECT, '0, '1);
      send_item(FUNC_QUERY, key_pool[2], '0);
      settle();
      write_reg(CSR_ENABLE, 32'd1);
      write_reg(CSR_MIN_ACC, 32'hFFFF_FFFF);
      write_reg(CSR_THRESHOLD, 32'h0001_FFFF);
      send_item(FUNC_DETECT, '0, '0);
      send_item(FUNC_LIST, '0, '0);
      settle();
      write_reg(CSR_MIN_ACC, 32'd0);
      write_reg(CSR_THRESHOLD, 32'd0);
      // Fill the table and overflow it.
      for (int n = 0; n < 34; n++) send_item(FUNC_ABORT, rand64(), '0);
      send_item(FUNC_DETECT, '0, '1);

      // Long response hold-off while the sender keeps offering items.
      hold_off = 1'b1;
      send_item(FUNC_LIST, '0, '0);
      send_item(FUNC_LIST, '0, '0);
      for (int n = 0; n < 6; n++) send_item(FUNC_QUERY, rand64(), '0);
      settle();

      // Random phases over several settings; no reset comes between them, so the table keeps its entries.
      random_phase(90, 10);
      settle();
      write_reg(CSR_THRESHOLD, 32'd65536);
      write_reg(CSR_MIN_ACC, 32'd2);
      random_phase(90, 5);
      settle();
      write_reg(CSR_THRESHOLD, $urandom_range(0, 131071));
      write_reg(CSR_MIN_ACC, $urandom_range(0, 4));
      write_reg(CSR_ENABLE, 32'd0);
      random_phase(30, 20);
      settle();
      write_reg(CSR_ENABLE, 32'd1);
      write_reg(CSR_THRESHOLD, 32'd16384);
      random_phase(110, 5);

      @(posedge clock iff pending_count == 0);
      repeat (40) @(posedge clock);
      if (fail_count == 0) begin
         $display("hot_object_abort_rate_detector_core test passed");
      end else begin
         $display("hot_object_abort_rate_detector_core test failed");
      end
      $finish;
   end
endmodule
